// File: rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_FINISH = 1'b1
  } req_e;

  // classified command from front to back
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        status;
  } res_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = K0;
    else if (r < 7'd40) k = K1;
    else if (r < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha1_req_if.sv
// ----------------------------------------------------------------------------
// sha1_req_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_res_if.sv
// ----------------------------------------------------------------------------
// sha1_res_if
// Valid/ready channel carrying one digest result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        status;

  modport source (output valid, digest_word, word_index, last_word, status, input ready);
  modport sink (input valid, digest_word, word_index, last_word, status, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 over a byte stream: queued front end and an iterative round core.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   req_type, data_byte
//  res      out  digest_word, word_index, last_word, status
//
//  an append stores its byte; the 64th byte of a block also starts the
//  compression: 80 rounds, one per cycle, then the chaining add
//  a finish runs one or two padded blocks, then five results (one error if too long)
//  reset clears all state but the queue storage asynchronously; no clearing pass
//  a two-entry queue lets requests in while the core compresses
`default_nettype none

module sha1_byte_stream_hasher_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  sha1_req_if.sink     req,
  sha1_res_if.source   res
);

  sha1_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_pop;

  sha1_front u_front (
    .clk_i, .rst_ni, .req,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  sha1_core u_core (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .res
  );

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.status |-> res.last_word && res.digest_word == '0)
    else $error("error item malformed");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.status |-> (res.last_word == (res.word_index == 3'd4)))
    else $error("last flag mismatch");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// Accepts request items, classifies them and queues commands for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  sha1_req_if.sink            req,
  output sha1_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire                 cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(sha1_pkg::QueueDepth);

  sha1_pkg::cmd_t        mem_q [sha1_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [PtrW:0]         cnt_q;
  logic                  push, pop;

  assign req.ready   = (cnt_q != (PtrW+1)'(sha1_pkg::QueueDepth));
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{finish: (req.req_type == sha1_pkg::REQ_FINISH),
                       data: req.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PtrW'(1);
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/sha1_core.sv
// ----------------------------------------------------------------------------
// sha1_core
// Block buffer, bit counter, padding and an iterative 80-round compression.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire sha1_pkg::cmd_t cmd_i,
  input  wire                 cmd_valid_i,
  output logic                cmd_pop_o,
  sha1_res_if.source          res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_RUN, ST_ADD, ST_EMIT
  } state_e;

  state_e        state_q;
  logic [31:0]   h_q [5];
  logic [31:0]   a_q, b_q, c_q, d_q, e_q;
  logic [31:0]   w_q [16];   // message schedule window, doubles as block buffer
  logic [63:0]   bits_q;
  logic [5:0]    fill_q;
  logic          too_long_q;
  logic [6:0]    rnd_q;
  logic          final_q;    // compressing the last padded block
  logic          second_q;   // length goes into a second block
  logic [2:0]    idx_q;
  sha1_pkg::res_t out_q;
  logic          out_valid_q;

  logic [31:0]   w_new, t_sum;
  logic [63:0]   bits_inc;
  logic          out_free;

  assign out_free  = !out_valid_q || res.ready;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign bits_inc  = bits_q + 64'd8;
  assign w_new = sha1_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 5'd1);
  assign t_sum = sha1_pkg::rotl(a_q, 5'd5) + sha1_pkg::round_f(rnd_q, b_q, c_q, d_q)
               + e_q + w_q[0] + sha1_pkg::round_k(rnd_q);

  assign res.valid       = out_valid_q;
  assign res.digest_word = out_q.digest_word;
  assign res.word_index  = out_q.word_index;
  assign res.last_word   = out_q.last_word;
  assign res.status      = out_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q         <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                       sha1_pkg::H4};
      bits_q      <= '0;
      fill_q      <= '0;
      too_long_q  <= 1'b0;
      rnd_q       <= '0;
      final_q     <= 1'b0;
      second_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
      w_q <= '{default: '0};
    end else begin
      if (out_valid_q && res.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (!cmd_i.finish) begin
              if (!too_long_q) begin
                w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= cmd_i.data;
                fill_q <= fill_q + 6'd1;
                bits_q <= bits_inc;
                if (bits_inc == '0) too_long_q <= 1'b1;
                if (fill_q == 6'd63) begin
                  final_q <= 1'b0;
                  state_q <= ST_RUN;
                  rnd_q   <= '0;
                  {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
                end
              end
            end else if (too_long_q) begin
              out_q       <= '{digest_word: '0, word_index: '0, last_word: 1'b1,
                               status: 1'b1};
              out_valid_q <= 1'b1;
              h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                       sha1_pkg::H4};
              bits_q     <= '0;
              fill_q     <= '0;
              too_long_q <= 1'b0;
            end else begin
              // place the pad byte, clear the rest of the block
              for (int i = 0; i < 64; i++) begin
                if (6'(i) == fill_q) w_q[i/4][8*(3-i%4) +: 8] <= sha1_pkg::PadByte;
                else if (6'(i) > fill_q) w_q[i/4][8*(3-i%4) +: 8] <= 8'h00;
              end
              second_q <= (fill_q > 6'd55);
              state_q  <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!second_q) begin
            w_q[14] <= bits_q[63:32];
            w_q[15] <= bits_q[31:0];
            final_q <= 1'b1;
          end else begin
            final_q <= 1'b0;
          end
          rnd_q   <= '0;
          {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          e_q <= d_q; d_q <= c_q; c_q <= sha1_pkg::rotl(b_q, 5'd30);
          b_q <= a_q; a_q <= t_sum;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_new;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= ST_ADD;
        end
        ST_ADD: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          fill_q <= '0;
          if (final_q) begin
            idx_q   <= '0;
            state_q <= ST_EMIT;
          end else if (second_q) begin
            // length-only block
            w_q      <= '{default: '0};
            second_q <= 1'b0;
            state_q  <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q       <= '{digest_word: h_q[idx_q], word_index: idx_q,
                             last_word: (idx_q == 3'd4), status: 1'b0};
            out_valid_q <= 1'b1;
            idx_q       <= idx_q + 3'd1;
            if (idx_q == 3'd4) begin
              h_q <= '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3,
                       sha1_pkg::H4};
              bits_q  <= '0;
              final_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: dv/sha1_byte_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit_test
// Streams byte messages through the hasher with random gaps on both channels.
// An in-bench SHA-1 predictor queues the expected digest words for each
// finish, and every result is checked field by field against that queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hasher_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit = 1000000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned TargetItems = 450;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha1_req_if req ();
  sha1_res_if res ();

  sha1_byte_stream_hasher_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .res   (res.source)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [31:0] hash_words[5];
  logic [63:0] msg_bits;
  logic [7:0]  blk_bytes[64];
  int unsigned blk_fill;
  logic        msg_too_long;

  sha1_pkg::res_t digest_q[$];
  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned cycles;
  bit          no_gaps;

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic start_message();
    hash_words[0] = sha1_pkg::H0;
    hash_words[1] = sha1_pkg::H1;
    hash_words[2] = sha1_pkg::H2;
    hash_words[3] = sha1_pkg::H3;
    hash_words[4] = sha1_pkg::H4;
    msg_bits = '0;
    blk_fill = 0;
    msg_too_long = 1'b0;
  endtask

  task automatic fold_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = rol(a, 5) + f + e + w[r] + k;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
    blk_fill = 0;
  endtask

  task automatic predict_digest(input sha1_pkg::req_e kind, input logic [7:0] byte_in);
    sha1_pkg::res_t r;
    int unsigned pos;
    if (kind == sha1_pkg::REQ_APPEND) begin
      if (msg_too_long) return;
      blk_bytes[blk_fill] = byte_in;
      blk_fill++;
      msg_bits += 64'd8;
      if (msg_bits == '0) msg_too_long = 1'b1;
      if (blk_fill == 64) fold_block();
      return;
    end
    if (msg_too_long) begin
      r = '{digest_word: '0, word_index: 3'd0, last_word: 1'b1, status: 1'b1};
      digest_q.push_back(r);
      start_message();
      return;
    end
    pos = blk_fill;
    blk_bytes[pos++] = sha1_pkg::PadByte;
    // no room for the length: pad out and fold an extra block
    if (pos > 56) begin
      while (pos < 64) blk_bytes[pos++] = 8'h00;
      fold_block();
      pos = 0;
    end
    while (pos < 56) blk_bytes[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
    fold_block();
    for (int i = 0; i < 5; i++) begin
      r.digest_word = hash_words[i];
      r.word_index = 3'(i);
      r.last_word = (i == 4);
      r.status = 1'b0;
      digest_q.push_back(r);
    end
    start_message();
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (no_gaps || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_item(input sha1_pkg::req_e kind, input logic [7:0] byte_in);
    int unsigned gap;
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.data_byte <= byte_in;
    do @(posedge clk_i); while (!req.ready);
    predict_digest(kind, byte_in);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      req.req_type <= 1'($urandom);
      req.data_byte <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(sha1_pkg::REQ_APPEND, 8'($urandom));
    // data byte is a don't-care on finish, so randomize it
    send_item(sha1_pkg::REQ_FINISH, 8'($urandom));
  endtask

  task automatic test_known_vectors();
    send_item(sha1_pkg::REQ_FINISH, 8'hff);
    send_item(sha1_pkg::REQ_APPEND, 8'h61);
    send_item(sha1_pkg::REQ_APPEND, 8'h62);
    send_item(sha1_pkg::REQ_APPEND, 8'h63);
    send_item(sha1_pkg::REQ_FINISH, 8'h00);
  endtask

  task automatic test_byte_extremes();
    send_item(sha1_pkg::REQ_APPEND, 8'h00);
    send_item(sha1_pkg::REQ_APPEND, 8'hff);
    send_item(sha1_pkg::REQ_APPEND, 8'h80);
    send_item(sha1_pkg::REQ_APPEND, 8'h7f);
    send_item(sha1_pkg::REQ_FINISH, 8'h55);
    send_item(sha1_pkg::REQ_APPEND, 8'hff);
    send_item(sha1_pkg::REQ_FINISH, 8'haa);
  endtask

  task automatic test_random_messages();
    int unsigned edges[8] = '{55, 56, 63, 64, 119, 120, 127, 128};
    bit paused;
    int unsigned len;
    paused = 1'b0;
    while (items_sent < TargetItems) begin
      no_gaps = ($urandom_range(9) < 2);
      if (!paused && items_sent > TargetItems / 2) begin
        // hold off until every queued digest word has come back
        paused = 1'b1;
        req.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(9) < 2) len = edges[$urandom_range(7)];
      else len = $urandom_range(40);
      // keep the total close to the item budget
      if (items_sent + len + 1 > TargetItems) len = TargetItems - items_sent - 1;
      send_message(len);
    end
    no_gaps = 1'b0;
  endtask

  // result side: random stalls, checked at each accepted item
  int unsigned stall_left;
  always @(posedge clk_i) begin
    sha1_pkg::res_t want;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(99) < 25) begin
        stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3, 1)
                                                : $urandom_range(40, 10);
      end
    end
    if (rst_ni && res.valid && res.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: word %h idx %0d",
                                       res.digest_word, res.word_index);
      end else begin
        want = digest_q.pop_front();
        if (res.digest_word !== want.digest_word || res.word_index !== want.word_index ||
            res.last_word !== want.last_word || res.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp word %h idx %0d last %b status %b", want.digest_word,
                     want.word_index, want.last_word, want.status);
            $display("          got word %h idx %0d last %b status %b", res.digest_word,
                     res.word_index, res.last_word, res.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = sha1_pkg::REQ_APPEND;
    req.data_byte = 8'h00;
    res.ready = 1'b0;
    stall_left = 0;
    cycles = 0;
    items_sent = 0;
    mismatches = 0;
    no_gaps = 1'b0;
    start_message();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_known_vectors();
    test_byte_extremes();
    test_random_messages();
    req.valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/sha1_pkg.sv
rtl/sha1_req_if.sv
rtl/sha1_res_if.sv
rtl/sha1_front.sv
rtl/sha1_core.sv
rtl/sha1_byte_stream_hasher_unit.sv
dv/sha1_byte_stream_hasher_unit_test.sv
